@@ hdl/servo_sweep_controller_assert.svh @@
// Assertion helpers for the servo sweep controller.
`ifndef SERVO_SWEEP_CONTROLLER_ASSERT_SVH
`define SERVO_SWEEP_CONTROLLER_ASSERT_SVH

// Same-cycle implication.
`define SVC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define SVC_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/svc_pkg.sv @@
`default_nettype none

package svc_pkg;

	localparam int unsigned ANGLE_W   = 8;
	localparam int unsigned PULSE_W   = 15;
	localparam int unsigned TICK_W    = 5;
	localparam int unsigned REQ_W     = 16;
	localparam int unsigned ANGLE_MAX = 180;
	localparam int unsigned CENTER_RST = 90;
	localparam int unsigned ANGLE_RST  = (CENTER_RST > ANGLE_MAX) ? ANGLE_MAX : CENTER_RST;
	localparam int unsigned PMIN_RST   = 500;
	localparam int unsigned PMAX_RST   = 2500;

	localparam logic [ANGLE_W-1:0] ANGLE_LIM = ANGLE_W'(ANGLE_MAX);
	localparam logic [PULSE_W-1:0] PULSE_SAT = '1;

	// angle*diff is at most 23 bits; /180 is done as (x>>2)/45 by reciprocal
	localparam int unsigned PROD_W    = ANGLE_W + PULSE_W;
	localparam int unsigned DIV_X_W   = PROD_W - 2;
	localparam int unsigned DIV_D     = ANGLE_MAX / 4;
	localparam int unsigned DIV_SHIFT = 27;
	localparam int unsigned DIV_M_W   = 22;
	localparam logic [DIV_M_W-1:0] DIV_MUL =
		DIV_M_W'(((64'd1 << DIV_SHIFT) + DIV_D - 1) / DIV_D);
	localparam int unsigned DIV_P_W   = DIV_X_W + DIV_M_W;

	localparam logic ACT_TICK = 1'b0;
	localparam logic ACT_SET  = 1'b1;

	typedef enum logic [1:0] {
		MODE_WIDE   = 2'd0,
		MODE_MID    = 2'd1,
		MODE_NARROW = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		CFG_MODE   = 2'd0,
		CFG_CENTER = 2'd1,
		CFG_PMIN   = 2'd2,
		CFG_PMAX   = 2'd3
	} cfg_addr_t;

	typedef struct packed {
		logic               action;
		logic signed [REQ_W-1:0] angle_request;
	} req_t;

	typedef struct packed {
		logic [ANGLE_W-1:0] angle_now;
		logic [PULSE_W-1:0] pulse_width_us;
		logic               stepped;
		logic               moving_down;
	} rsp_t;

	typedef struct packed {
		logic [1:0]         sweep_mode;
		logic [ANGLE_W-1:0] center_angle;
		logic [PULSE_W-1:0] pulse_min_us;
		logic [PULSE_W-1:0] pulse_max_us;
	} cfg_t;

	typedef struct packed {
		logic [ANGLE_W-1:0] angle;
		logic               stepped;
		logic               down;
	} sweep_t;

	function automatic logic [ANGLE_W-1:0] span_of(input logic [1:0] mode);
		logic [ANGLE_W-1:0] s;
		unique case (mode)
			MODE_WIDE:   s = ANGLE_W'(180);
			MODE_MID:    s = ANGLE_W'(90);
			MODE_NARROW: s = ANGLE_W'(45);
			default:     s = ANGLE_W'(180);
		endcase
		return s;
	endfunction

	function automatic logic [TICK_W-1:0] step_of(input logic [1:0] mode);
		logic [TICK_W-1:0] t;
		unique case (mode)
			MODE_WIDE:   t = TICK_W'(20);
			MODE_MID:    t = TICK_W'(12);
			MODE_NARROW: t = TICK_W'(8);
			default:     t = TICK_W'(20);
		endcase
		return t;
	endfunction

endpackage

`default_nettype wire

@@ hdl/servo_sweep_controller.sv @@
// channel  | handshake                | payload
// ---------+--------------------------+---------------------------------
// request  | req_valid / req_ready    | req_data  (action, angle_request)
// response | rsp_valid / rsp_ready    | rsp_data  (angle, pulse, flags)
// config   | cfg_we                   | cfg_addr, cfg_wdata
//
// One request per cycle while req_ready is high; an accepted request moves
// through stage 1, stage 2 and stage 3 in order, and stage 3 drives rsp_valid.
// Sweep state updates at the accepting edge, pulse math takes two more stages
// (angle times pulse range, then reciprocal divide by 180 and add).
// Each stage stalls only when its successor is full; req_ready drops only
// when all three stages hold responses and rsp_ready is low.
// arst_n clears valids and sweep state; config resets to mode 0, centre 90,
// 500..2500 us.
`default_nettype none

`include "servo_sweep_controller_assert.svh"

module servo_sweep_controller (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        req_valid,
	output logic                             req_ready,
	input  wire svc_pkg::req_t               req_data,
	output logic                             rsp_valid,
	input  wire logic                        rsp_ready,
	output svc_pkg::rsp_t                    rsp_data,
	input  wire logic                        cfg_we,
	input  wire logic [1:0]                  cfg_addr,
	input  wire logic [svc_pkg::PULSE_W-1:0] cfg_wdata
);

	svc_pkg::cfg_t   cfg_q;
	svc_pkg::sweep_t nxt;
	svc_pkg::sweep_t sweep_s1;
	logic            v1_q;
	logic            v2_q;
	logic            v3_q;
	logic            rdy1;
	logic            rdy2;
	logic            rdy3;
	logic            req_fire;

	assign rdy3      = !v3_q || rsp_ready;
	assign rdy2      = !v2_q || rdy3;
	assign rdy1      = !v1_q || rdy2;
	assign req_ready = rdy1;
	assign req_fire  = req_valid && rdy1;
	assign rsp_valid = v3_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sweep_mode   <= svc_pkg::MODE_WIDE;
			cfg_q.center_angle <= svc_pkg::ANGLE_W'(svc_pkg::CENTER_RST);
			cfg_q.pulse_min_us <= svc_pkg::PULSE_W'(svc_pkg::PMIN_RST);
			cfg_q.pulse_max_us <= svc_pkg::PULSE_W'(svc_pkg::PMAX_RST);
		end else if (cfg_we) begin
			unique case (svc_pkg::cfg_addr_t'(cfg_addr))
				svc_pkg::CFG_MODE: begin
					if (cfg_wdata[1:0] == svc_pkg::MODE_WIDE ||
							cfg_wdata[1:0] == svc_pkg::MODE_MID ||
							cfg_wdata[1:0] == svc_pkg::MODE_NARROW) begin
						cfg_q.sweep_mode <= cfg_wdata[1:0];
					end
				end
				svc_pkg::CFG_CENTER: cfg_q.center_angle <= cfg_wdata[svc_pkg::ANGLE_W-1:0];
				svc_pkg::CFG_PMIN:   cfg_q.pulse_min_us <= cfg_wdata;
				svc_pkg::CFG_PMAX:   cfg_q.pulse_max_us <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			v3_q <= 1'b0;
		end else begin
			if (rdy1) begin
				v1_q <= req_valid;
			end
			if (rdy2) begin
				v2_q <= v1_q;
			end
			if (rdy3) begin
				v3_q <= v2_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			sweep_s1 <= nxt;
		end
	end

	svc_sweep u_sweep (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (req_fire),
		.req     (req_data),
		.cfg     (cfg_q),
		.nxt     (nxt)
	);

	svc_pulse u_pulse (
		.clk   (clk),
		.adv2  (rdy2),
		.adv3  (rdy3),
		.sweep (sweep_s1),
		.cfg   (cfg_q),
		.rsp   (rsp_data)
	);

	`SVC_ASSERT_NOW(a_drain_frees_input, rsp_valid && rsp_ready, req_ready, "taken response did not free input")
	`SVC_ASSERT_NXT(a_cmd_no_step, req_fire && req_data.action == svc_pkg::ACT_SET, v1_q && !sweep_s1.stepped, "angle command flagged a step")
	`SVC_ASSERT_NOW(a_pulse_floor, rsp_valid, rsp_data.pulse_width_us >= cfg_q.pulse_min_us, "pulse below minimum")

endmodule

`default_nettype wire

@@ hdl/svc_sweep.sv @@
`default_nettype none

module svc_sweep (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           advance,
	input  wire svc_pkg::req_t  req,
	input  wire svc_pkg::cfg_t  cfg,
	output svc_pkg::sweep_t     nxt
);

	logic [svc_pkg::ANGLE_W-1:0] angle_q;
	logic                        down_q;
	logic [svc_pkg::TICK_W-1:0]  ticks_q;

	logic [svc_pkg::TICK_W-1:0]  tick_inc;
	logic [svc_pkg::TICK_W-1:0]  step_time;
	logic [svc_pkg::ANGLE_W-1:0] span;
	logic [svc_pkg::ANGLE_W-1:0] half;
	logic [svc_pkg::ANGLE_W-1:0] lo;
	logic [svc_pkg::ANGLE_W:0]   hi_sum;
	logic [svc_pkg::ANGLE_W-1:0] hi;
	logic                        do_step;
	logic                        dir_new;
	logic [svc_pkg::ANGLE_W-1:0] ang_step;
	logic [svc_pkg::ANGLE_W-1:0] ang_cmd;
	logic [svc_pkg::TICK_W-1:0]  ticks_nxt;

	always_comb begin
		tick_inc  = (ticks_q == '1) ? ticks_q : ticks_q + svc_pkg::TICK_W'(1);
		step_time = svc_pkg::step_of(cfg.sweep_mode);
		span      = svc_pkg::span_of(cfg.sweep_mode);
		half      = span >> 1;
		lo        = (cfg.center_angle >= half) ? cfg.center_angle - half : '0;
		hi_sum    = {1'b0, lo} + {1'b0, span};
		hi        = (hi_sum > {1'b0, svc_pkg::ANGLE_LIM}) ? svc_pkg::ANGLE_LIM
			: hi_sum[svc_pkg::ANGLE_W-1:0];
		do_step   = (req.action == svc_pkg::ACT_TICK) && (tick_inc >= step_time);

		if (angle_q >= hi) begin
			dir_new = 1'b1;
		end else if (angle_q <= lo) begin
			dir_new = 1'b0;
		end else begin
			dir_new = down_q;
		end

		if (dir_new) begin
			ang_step = (angle_q == '0) ? '0 : angle_q - svc_pkg::ANGLE_W'(1);
		end else begin
			ang_step = (angle_q >= svc_pkg::ANGLE_LIM) ? svc_pkg::ANGLE_LIM
				: angle_q + svc_pkg::ANGLE_W'(1);
		end

		if (req.angle_request[svc_pkg::REQ_W-1]) begin
			ang_cmd = '0;
		end else if (req.angle_request[svc_pkg::REQ_W-2:0] >
				(svc_pkg::REQ_W-1)'(svc_pkg::ANGLE_MAX)) begin
			ang_cmd = svc_pkg::ANGLE_LIM;
		end else begin
			ang_cmd = req.angle_request[svc_pkg::ANGLE_W-1:0];
		end

		nxt.stepped = 1'b0;
		nxt.down    = down_q;
		nxt.angle   = angle_q;
		ticks_nxt   = ticks_q;
		if (req.action == svc_pkg::ACT_SET) begin
			nxt.angle = ang_cmd;
		end else if (do_step) begin
			nxt.angle   = ang_step;
			nxt.down    = dir_new;
			nxt.stepped = 1'b1;
			ticks_nxt   = '0;
		end else begin
			ticks_nxt = tick_inc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			angle_q <= svc_pkg::ANGLE_W'(svc_pkg::ANGLE_RST);
			down_q  <= 1'b0;
			ticks_q <= '0;
		end else if (advance) begin
			angle_q <= nxt.angle;
			down_q  <= nxt.down;
			ticks_q <= ticks_nxt;
		end
	end

endmodule

`default_nettype wire

@@ hdl/svc_pulse.sv @@
`default_nettype none

module svc_pulse (
	input  wire logic            clk,
	input  wire logic            adv2,
	input  wire logic            adv3,
	input  wire svc_pkg::sweep_t sweep,
	input  wire svc_pkg::cfg_t   cfg,
	output svc_pkg::rsp_t        rsp
);

	logic [svc_pkg::PULSE_W-1:0] diff;
	svc_pkg::sweep_t             sweep_s2;
	logic [svc_pkg::PROD_W-1:0]  prod_s2;
	logic [svc_pkg::DIV_P_W-1:0] qprod;
	logic [svc_pkg::PULSE_W:0]   quot;
	logic [svc_pkg::PULSE_W:0]   sum;
	svc_pkg::rsp_t               rsp_s3;

	assign diff = (cfg.pulse_max_us > cfg.pulse_min_us) ? cfg.pulse_max_us - cfg.pulse_min_us : '0;

	always_ff @(posedge clk) begin
		if (adv2) begin
			sweep_s2 <= sweep;
			prod_s2  <= svc_pkg::PROD_W'(sweep.angle) * svc_pkg::PROD_W'(diff);
		end
	end

	// floor(prod/180) = floor((prod>>2)/45), exact by reciprocal for 21-bit values
	always_comb begin
		qprod = svc_pkg::DIV_P_W'(prod_s2[svc_pkg::PROD_W-1:2]) * svc_pkg::DIV_P_W'(svc_pkg::DIV_MUL);
		quot  = qprod[svc_pkg::DIV_SHIFT +: (svc_pkg::PULSE_W + 1)];
		sum   = {1'b0, cfg.pulse_min_us} + quot;
	end

	always_ff @(posedge clk) begin
		if (adv3) begin
			rsp_s3.angle_now      <= sweep_s2.angle;
			rsp_s3.pulse_width_us <= sum[svc_pkg::PULSE_W] ? svc_pkg::PULSE_SAT
				: sum[svc_pkg::PULSE_W-1:0];
			rsp_s3.stepped        <= sweep_s2.stepped;
			rsp_s3.moving_down    <= sweep_s2.down;
		end
	end

	assign rsp = rsp_s3;

endmodule

`default_nettype wire
